@@ rtl/core/sha256_pkg.sv @@
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef logic [31:0] word_t;

    localparam word_t START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic word_t ror(input word_t x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

endpackage

@@ rtl/core/sha256_stream_hasher.sv @@
// Channel   | Dir | tdata fields (low bit up)     | tuser        | tlast
// s_axis    | in  | data_byte[7:0]                | byte_present | message_end
// m_axis    | out | digest_word[31:0]             | word_index   | last_word
//
// A byte that is present is written into the block buffer. A full block or a
// padded block runs 64 rounds through one shared round unit, one round per
// cycle, and then a fold step adds the working words into the chaining words.
// The end of a message costs one or two padding blocks and eight output
// transfers. rst_n is asynchronous and loads the initial hash values. The
// input is not ready while rounds run or digest words wait; a stalled
// output simply holds its word.
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // message_end
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);
    import sha256_pkg::*;

    state_t      state_reg, state_next;
    word_t       hash_reg [8];
    word_t       var_reg [8];
    word_t       w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic        two_reg;     // padding needs a second block
    logic        fin_reg;     // block under compression is the last one
    logic        second_reg;  // second padding block under way
    logic [2:0]  out_idx_reg;

    // The block buffer is kept as sixteen big-endian words.
    logic        acc;
    logic [3:0]  wsel;
    logic [1:0]  bsel;
    word_t       wt, s0, s1, t1, t2, sig0, sig1, ch, maj;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign wsel = fill_reg[5:2];
    assign bsel = fill_reg[1:0];

    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = hash_reg[out_idx_reg];
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

    always_comb
    begin
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        // The window shifts each round, so position 0 is always W[t].
        wt = w_reg[0];
        sig1 = ror(var_reg[4], 6) ^ ror(var_reg[4], 11) ^ ror(var_reg[4], 25);
        ch   = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        sig0 = ror(var_reg[0], 2) ^ ror(var_reg[0], 13) ^ ror(var_reg[0], 22);
        maj  = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
             ^ (var_reg[1] & var_reg[2]);
        t1 = var_reg[7] + sig1 + ch + ROUND_K[round_reg] + wt;
        t2 = sig0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (s_axis_tuser && fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (s_axis_tlast)
                        state_next = ST_PAD;
                end
            ST_PAD:   state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD:
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (two_reg && !second_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_EMIT;
            ST_EMIT:
                if (m_axis_tready && out_idx_reg == 3'd7)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            round_reg   <= '0;
            two_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            second_reg  <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= START_HASH[i];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (acc)
                    begin
                        if (s_axis_tuser)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            len_reg  <= len_reg + 64'd8;
                        end
                        fin_reg    <= s_axis_tlast;
                        second_reg <= 1'b0;
                        // A full block with an end mark still needs a pad block.
                        two_reg <= s_axis_tuser && fill_reg == 6'd63;
                    end
                ST_PAD:
                begin
                    // The fill level is kept so that the second block knows
                    // whether the pad byte has already been placed.
                    if (second_reg || !two_reg)
                    begin
                        if (!two_reg && fill_reg >= LEN_START)
                            two_reg <= 1'b1;
                    end
                end
                ST_ROUND:
                    round_reg <= round_reg + 6'd1;
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + var_reg[i];
                    if (fin_reg && two_reg && !second_reg)
                        second_reg <= 1'b1;
                end
                ST_EMIT:
                    if (m_axis_tready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= START_HASH[i];
                            len_reg  <= '0;
                            fill_reg <= '0;
                            fin_reg  <= 1'b0;
                            two_reg  <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    // Datapath storage: block words, working words.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (s_axis_tuser)
                    begin
                        w_reg[wsel][8*(3-bsel) +: 8] <= s_axis_tdata;
                        if (fill_reg == 6'd63)
                            for (int i = 0; i < 8; i++)
                                var_reg[i] <= hash_reg[i];
                        else if (s_axis_tlast)
                            w_reg[wsel][8*(3-bsel) +: 8] <= s_axis_tdata;
                    end
                end
            ST_PAD:
            begin
                // Pad bytes and, when it fits, the bit count. A second block
                // after an exactly full block starts with the pad byte; after
                // a part-filled block it holds only zeros and the count.
                for (int j = 0; j < 64; j++)
                begin
                    if (second_reg)
                        w_reg[j/4][8*(3-(j%4)) +: 8] <= (j == 0 && fill_reg == 6'd0)
                                                        ? PAD_BYTE : 8'h00;
                    else if (6'(j) == fill_reg)
                        w_reg[j/4][8*(3-(j%4)) +: 8] <= PAD_BYTE;
                    else if (6'(j) > fill_reg)
                        w_reg[j/4][8*(3-(j%4)) +: 8] <= 8'h00;
                end
                if (second_reg || fill_reg < LEN_START)
                begin
                    w_reg[14] <= len_reg[63:32];
                    w_reg[15] <= len_reg[31:0];
                end
                for (int i = 0; i < 8; i++)
                    var_reg[i] <= hash_reg[i];
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= s1 + w_reg[9] + s0 + w_reg[0];
                var_reg[7] <= var_reg[6];
                var_reg[6] <= var_reg[5];
                var_reg[5] <= var_reg[4];
                var_reg[4] <= var_reg[3] + t1;
                var_reg[3] <= var_reg[2];
                var_reg[2] <= var_reg[1];
                var_reg[1] <= var_reg[0];
                var_reg[0] <= t1 + t2;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/core/sha256_stream_hasher_checker.sv @@
module sha256_stream_hasher_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);
    // No input is taken while a digest is offered.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during digest output");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("last flag does not match word index");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest words not consecutive");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled digest word changed");
endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import sha256_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;

    sha256_stream_hasher dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),   // data_byte
        .s_axis_tuser  (s_axis_tuser),   // byte_present
        .s_axis_tlast  (s_axis_tlast),   // message_end
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // digest_word
        .m_axis_tuser  (m_axis_tuser),   // word_index
        .m_axis_tlast  (m_axis_tlast),   // last_word
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Predictor state: a private copy of the hash engine.
    word_t       hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] msg_bits;

    byte_item_t   pending_bytes [$];
    digest_item_t expected_digests [$];
    int           error_count;
    int           cycle_count;
    bit           stimulus_done;
    bit           calm_phase;
    bit           last_taken;

    function automatic word_t rotr(word_t x, int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    // One 64-round compression of msg_block into hash_state.
    task automatic compress_msg_block();
        word_t w [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        v = hash_state;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
        begin
            hash_state[j] = hash_state[j] + v[j];
        end
    endtask

    task automatic restart_message();
        hash_state = START_HASH;
        block_fill = 0;
        msg_bits   = '0;
    endtask

    // Applies one accepted transfer and queues any digest words it yields.
    task automatic predict_digest(byte_item_t it);
        int unsigned n;
        digest_item_t d;
        if (it.byte_present)
        begin
            msg_block[block_fill] = it.data_byte;
            block_fill++;
            msg_bits += 64'd8;
            if (block_fill == 64)
            begin
                compress_msg_block();
                block_fill = 0;
            end
        end
        if (it.message_end)
        begin
            n = block_fill;
            msg_block[n] = PAD_BYTE;
            for (int j = n + 1; j < 64; j++)
            begin
                msg_block[j] = 8'h00;
            end
            // No room left for the length, so an extra block is needed.
            if (n >= LEN_START)
            begin
                compress_msg_block();
                for (int j = 0; j < 64; j++)
                begin
                    msg_block[j] = 8'h00;
                end
            end
            for (int j = 0; j < 8; j++)
            begin
                msg_block[56 + j] = msg_bits[63 - 8*j -: 8];
            end
            compress_msg_block();
            for (int j = 0; j < 8; j++)
            begin
                d.digest_word = hash_state[j];
                d.word_index  = j[2:0];
                d.last_word   = (j == 7);
                expected_digests.push_back(d);
            end
            restart_message();
        end
    endtask

    function automatic byte_item_t make_item(logic [7:0] b, bit present, bit last_flag);
        byte_item_t it;
        it.data_byte    = b;
        it.byte_present = present;
        it.message_end  = last_flag;
        return it;
    endfunction

    task automatic queue_message(int unsigned len, bit end_with_byte);
        for (int i = 0; i < len; i++)
        begin
            pending_bytes.push_back(make_item($urandom_range(0, 255), 1'b1,
                                    end_with_byte && (i == len - 1)));
        end
        if (!end_with_byte || len == 0)
        begin
            pending_bytes.push_back(make_item($urandom_range(0, 255), 1'b0, 1'b1));
        end
    endtask

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Driver: presents the next pending item at the falling edge. A presented
    // item is held until the rising edge that takes it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || last_taken)
            begin
                if (pending_bytes.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 19))
                begin
                    {s_axis_tdata, s_axis_tuser, s_axis_tlast} <= pending_bytes[0];
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm_phase || ($urandom_range(0, 99) >= 19);
        end
    end

    // Input side: a transfer happens at the rising edge when both are high.
    always @(posedge clk)
    begin
        last_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (last_taken)
        begin
            predict_digest(pending_bytes.pop_front());
        end
    end

    // Monitor: compares each output transfer with the oldest expectation.
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_digests.size() == 0)
            begin
                $display("%0t: unexpected digest word %h index %0d last %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = expected_digests.pop_front();
                if (want.digest_word !== m_axis_tdata)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, want.digest_word, m_axis_tdata);
                    error_count++;
                end
                if (want.word_index !== m_axis_tuser)
                begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, want.word_index, m_axis_tuser);
                    error_count++;
                end
                if (want.last_word !== m_axis_tlast)
                begin
                    $display("%0t: last_word expected %0b actual %0b",
                             $time, want.last_word, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        stimulus_done = 1'b0;
        calm_phase    = 1'b0;
        for (int j = 0; j < 64; j++)
        begin
            msg_block[j] = 8'h00;
        end
        restart_message();

        // Directed: empty message, an ignored item, extremes of the byte, a
        // byte carried with the end mark, a message that needs a second pad
        // block, and a message that ends exactly on a full block.
        pending_bytes.push_back(make_item(8'h00, 1'b0, 1'b1));
        pending_bytes.push_back(make_item(8'hff, 1'b0, 1'b0));
        pending_bytes.push_back(make_item(8'hff, 1'b1, 1'b0));
        pending_bytes.push_back(make_item(8'h00, 1'b1, 1'b1));
        pending_bytes.push_back(make_item(8'haa, 1'b1, 1'b0));
        pending_bytes.push_back(make_item(8'h55, 1'b1, 1'b0));
        pending_bytes.push_back(make_item(8'h00, 1'b0, 1'b1));
        queue_message(56, 1'b1);
        queue_message(64, 1'b1);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A stretch without idling on either side partway through.
        repeat (300) @(posedge clk);
        calm_phase = 1'b1;
        repeat (400) @(posedge clk);
        calm_phase = 1'b0;

        while (pending_bytes.size() > 0 || expected_digests.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        if (error_count == 0 && expected_digests.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
